FILE: src/scegen_pkg.sv
// Shared types, constants and codes of the static colormap entry generator.
package scegen_pkg;

   localparam int IndexBits     = 10;
   localparam int OutBits       = 16;
   localparam int MaskBits      = 32;
   localparam int CountBits     = 11;
   localparam int BpcBits       = 5;
   localparam int KindBits      = 2;
   localparam int NumLanes      = 3;
   localparam int Div1Bits      = IndexBits + OutBits;
   localparam int QuoBits       = Div1Bits + OutBits;
   localparam int StepBits      = $clog2(QuoBits + 1);
   localparam int QueueDepth    = 2;
   localparam int CsrIndexBits  = 3;

   typedef enum logic [KindBits-1:0] {
      KIND_STATIC_GRAY  = 2'd0,
      KIND_STATIC_COLOR = 2'd1,
      KIND_TRUE_COLOR   = 2'd2,
      KIND_OTHER        = 2'd3
   } visual_kind_type;

   localparam logic [CsrIndexBits-1:0] CSR_VISUAL_KIND = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_BPC         = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_ENTRY_COUNT = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_RED_MASK    = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_GREEN_MASK  = 3'd4;
   localparam logic [CsrIndexBits-1:0] CSR_BLUE_MASK   = 3'd5;

   typedef struct packed {
      logic [IndexBits-1:0] num;
      logic [MaskBits-1:0]  den;
      logic                 norm;
      logic                 cut;
   } lane_task_type;

   typedef struct packed {
      logic                               skip;
      logic [BpcBits-1:0]                 bpc;
      lane_task_type [NumLanes-1:0]       lane;
   } task_type;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_NORM,
      LANE_DIV1,
      LANE_DIV2,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctrl_type;

   typedef struct packed {
      logic               idle;
      logic               done;
      logic               fault;
      logic [OutBits-1:0] value;
   } lane_status_type;

endpackage

FILE: src/scegen_front.sv
// Front part: configuration registers and classification of each item.
module scegen_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [scegen_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [scegen_pkg::MaskBits-1:0]       csr_write_data,
   input  logic [scegen_pkg::IndexBits-1:0]      req_entry_index,
   output scegen_pkg::task_type                  task_out
);

   logic [scegen_pkg::KindBits-1:0]  visual_kind_ff;
   logic [scegen_pkg::BpcBits-1:0]   bpc_ff;
   logic [scegen_pkg::CountBits-1:0] entry_count_ff;
   logic [scegen_pkg::MaskBits-1:0]  mask_ff [scegen_pkg::NumLanes];

   always_ff @(posedge clock) begin
      if (reset) begin
         visual_kind_ff <= scegen_pkg::KIND_TRUE_COLOR;
         bpc_ff         <= 5'd8;
         entry_count_ff <= 11'd256;
         mask_ff[0]     <= 32'h0000_00FF;
         mask_ff[1]     <= 32'h0000_FF00;
         mask_ff[2]     <= 32'h00FF_0000;
      end else if (csr_write_enable) begin
         case (csr_index)
            scegen_pkg::CSR_VISUAL_KIND: visual_kind_ff <= csr_write_data[scegen_pkg::KindBits-1:0];
            scegen_pkg::CSR_BPC:         bpc_ff         <= csr_write_data[scegen_pkg::BpcBits-1:0];
            scegen_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_write_data[scegen_pkg::CountBits-1:0];
            scegen_pkg::CSR_RED_MASK:    mask_ff[0]     <= csr_write_data;
            scegen_pkg::CSR_GREEN_MASK:  mask_ff[1]     <= csr_write_data;
            scegen_pkg::CSR_BLUE_MASK:   mask_ff[2]     <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [scegen_pkg::CountBits-1:0] grey_span;
   logic                             in_range;
   logic                             is_colour;
   logic                             is_cut;

   always_comb begin
      grey_span = entry_count_ff - 11'd1;
      in_range  = {1'b0, req_entry_index} < entry_count_ff;
      is_colour = (visual_kind_ff == scegen_pkg::KIND_TRUE_COLOR) ||
                  (visual_kind_ff == scegen_pkg::KIND_STATIC_COLOR);
      is_cut    = (visual_kind_ff == scegen_pkg::KIND_STATIC_COLOR);
      task_out.skip = (visual_kind_ff == scegen_pkg::KIND_OTHER) || !in_range;
      task_out.bpc  = (bpc_ff > 5'd16) ? 5'd16 : bpc_ff;
      for (int i = 0; i < scegen_pkg::NumLanes; i++) begin
         if (is_colour) begin
            task_out.lane[i].num  = is_cut ?
               (req_entry_index & mask_ff[i][scegen_pkg::IndexBits-1:0]) : req_entry_index;
            task_out.lane[i].den  = mask_ff[i];
            task_out.lane[i].norm = 1'b1;
            task_out.lane[i].cut  = is_cut;
         end else begin
            task_out.lane[i].num  = req_entry_index;
            task_out.lane[i].den  = {{(scegen_pkg::MaskBits-scegen_pkg::CountBits){1'b0}},
                                     grey_span};
            task_out.lane[i].norm = 1'b0;
            task_out.lane[i].cut  = 1'b0;
         end
      end
   end

endmodule

FILE: src/scegen_queue.sv
// Short queue of classified items between the front and back parts.
module scegen_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  scegen_pkg::task_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output scegen_pkg::task_type head
);

   localparam int PtrBits   = $clog2(scegen_pkg::QueueDepth);
   localparam int CountBits = $clog2(scegen_pkg::QueueDepth + 1);

   scegen_pkg::task_type slots_ff [scegen_pkg::QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   assign full  = (count_ff == CountBits'(scegen_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(scegen_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(scegen_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/scegen_lane.sv
// One channel lane: offset normalisation and two radix-2 restoring divisions.
module scegen_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  scegen_pkg::lane_ctrl_type ctrl,
   input  scegen_pkg::lane_task_type lane_task,
   input  logic                      skip,
   input  logic [scegen_pkg::BpcBits-1:0] bpc,
   output scegen_pkg::lane_status_type status
);

   localparam int Q  = scegen_pkg::QuoBits;
   localparam int D1 = scegen_pkg::Div1Bits;
   localparam int OB = scegen_pkg::OutBits;
   localparam int MB = scegen_pkg::MaskBits;

   scegen_pkg::lane_state_type state_ff, state_in;
   logic [scegen_pkg::IndexBits-1:0] num_ff, num_in;
   logic [MB-1:0]                    div_ff, div_in;
   logic [MB-1:0]                    rem_ff, rem_in;
   logic [Q-1:0]                     quo_ff, quo_in;
   logic [scegen_pkg::StepBits-1:0]  cnt_ff, cnt_in;
   logic [scegen_pkg::BpcBits-1:0]   bpc_ff, bpc_in;
   logic                             norm_ff, norm_in;
   logic                             cut_ff, cut_in;
   logic [OB-1:0]                    value_ff, value_in;
   logic                             fault_ff, fault_in;

   logic [MB:0]     trial;
   logic [MB:0]     diff;
   logic            fit;
   logic [D1-1:0]   quotient1;
   logic [D1-1:0]   scaled;
   logic [Q-1:0]    dividend2;
   logic [D1-1:0]   dividend1;
   logic [OB:0]     lim;
   logic [scegen_pkg::BpcBits-1:0] sh;

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      bpc_in   = bpc_ff;
      norm_in  = norm_ff;
      cut_in   = cut_ff;
      value_in = value_ff;
      fault_in = fault_ff;

      trial     = {rem_ff, quo_ff[Q-1]};
      fit       = trial >= {1'b0, div_ff};
      diff      = trial - {1'b0, div_ff};
      quotient1 = quo_ff[D1-1:0];
      sh        = 5'(OB) - bpc_ff;
      scaled    = quotient1 >> sh;
      dividend2 = {scaled, {OB{1'b0}}} - Q'(scaled);
      dividend1 = {num_ff, {OB{1'b0}}} - D1'(num_ff);
      lim       = ((OB+1)'(1) << bpc_ff) - (OB+1)'(1);

      case (state_ff)
         scegen_pkg::LANE_IDLE: begin
            if (ctrl.start) begin
               num_in   = lane_task.num;
               div_in   = lane_task.den;
               norm_in  = lane_task.norm;
               cut_in   = lane_task.cut;
               bpc_in   = bpc;
               value_in = '0;
               fault_in = 1'b0;
               state_in = skip ? scegen_pkg::LANE_DONE : scegen_pkg::LANE_NORM;
            end
         end
         scegen_pkg::LANE_NORM: begin
            if (norm_ff && (div_ff != '0) && !div_ff[0]) begin
               div_in = div_ff >> 1;
               if (cut_ff) begin
                  num_in = num_ff >> 1;
               end
            end else if ((div_ff == '0) || (bpc_ff == '0)) begin
               fault_in = 1'b1;
               value_in = '0;
               state_in = scegen_pkg::LANE_DONE;
            end else begin
               quo_in   = {dividend1, {OB{1'b0}}};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = scegen_pkg::LANE_DIV1;
            end
         end
         scegen_pkg::LANE_DIV1: begin
            if (cnt_ff == scegen_pkg::StepBits'(D1)) begin
               quo_in   = dividend2;
               rem_in   = '0;
               div_in   = {{(MB-OB){1'b0}}, lim[OB-1:0]};
               cnt_in   = '0;
               state_in = scegen_pkg::LANE_DIV2;
            end else begin
               rem_in = fit ? diff[MB-1:0] : trial[MB-1:0];
               quo_in = {quo_ff[Q-2:0], fit};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         scegen_pkg::LANE_DIV2: begin
            if (cnt_ff == scegen_pkg::StepBits'(Q)) begin
               value_in = quo_ff[OB-1:0];
               state_in = scegen_pkg::LANE_DONE;
            end else begin
               rem_in = fit ? diff[MB-1:0] : trial[MB-1:0];
               quo_in = {quo_ff[Q-2:0], fit};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         scegen_pkg::LANE_DONE: begin
            if (ctrl.ack) begin
               state_in = scegen_pkg::LANE_IDLE;
            end
         end
         default: state_in = scegen_pkg::LANE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scegen_pkg::LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      bpc_ff   <= bpc_in;
      norm_ff  <= norm_in;
      cut_ff   <= cut_in;
      value_ff <= value_in;
      fault_ff <= fault_in;
   end

   assign status.idle  = (state_ff == scegen_pkg::LANE_IDLE);
   assign status.done  = (state_ff == scegen_pkg::LANE_DONE);
   assign status.fault = fault_ff;
   assign status.value = value_ff;

endmodule

FILE: src/scegen_back.sv
// Back part: three channel lanes and the result register.
module scegen_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  scegen_pkg::task_type queue_head,
   output logic                 queue_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [scegen_pkg::OutBits-1:0] rsp_red_value,
   output logic [scegen_pkg::OutBits-1:0] rsp_green_value,
   output logic [scegen_pkg::OutBits-1:0] rsp_blue_value,
   output logic                 rsp_entry_written,
   output logic                 rsp_divide_fault
);

   scegen_pkg::lane_ctrl_type   lane_ctrl;
   scegen_pkg::lane_status_type lane_status [scegen_pkg::NumLanes];

   logic lanes_idle;
   logic lanes_done;
   logic any_fault;
   logic out_free;

   logic                           written_ff, written_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [scegen_pkg::OutBits-1:0] red_ff, green_ff, blue_ff;
   logic                           rsp_written_ff, rsp_fault_ff;

   for (genvar i = 0; i < scegen_pkg::NumLanes; i++) begin : g_lane
      scegen_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .lane_task (queue_head.lane[i]),
         .skip      (queue_head.skip),
         .bpc       (queue_head.bpc),
         .status    (lane_status[i])
      );
   end

   always_comb begin
      lanes_idle = 1'b1;
      lanes_done = 1'b1;
      any_fault  = 1'b0;
      for (int i = 0; i < scegen_pkg::NumLanes; i++) begin
         lanes_idle = lanes_idle & lane_status[i].idle;
         lanes_done = lanes_done & lane_status[i].done;
         any_fault  = any_fault | lane_status[i].fault;
      end
      out_free        = !rsp_valid_ff || rsp_pop;
      queue_pop       = !queue_empty && lanes_idle;
      lane_ctrl.start = queue_pop;
      lane_ctrl.ack   = lanes_done && out_free;
      written_in      = queue_pop ? !queue_head.skip : written_ff;
      if (lane_ctrl.ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      written_ff <= written_in;
      if (lane_ctrl.ack) begin
         red_ff         <= lane_status[0].value;
         green_ff       <= lane_status[1].value;
         blue_ff        <= lane_status[2].value;
         rsp_written_ff <= written_ff;
         rsp_fault_ff   <= any_fault;
      end
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_red_value     = red_ff;
   assign rsp_green_value   = green_ff;
   assign rsp_blue_value    = blue_ff;
   assign rsp_entry_written = rsp_written_ff;
   assign rsp_divide_fault  = rsp_fault_ff;

   // An unwritten entry carries all-zero fields.
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_written_ff) |->
         (red_ff == '0 && green_ff == '0 && blue_ff == '0 && !rsp_fault_ff))
      else $error("unwritten entry has non-zero fields");

   // A fault is only reported for an entry that is written.
   a_fault_written: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> rsp_written_ff)
      else $error("fault on an unwritten entry");

   // A waiting result is never overwritten before it is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pop) |=> (rsp_valid_ff && $stable(red_ff) && $stable(blue_ff)))
      else $error("waiting result overwritten");

   // Lanes are only started together from idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.start |=> !lanes_idle)
      else $error("lanes did not leave idle on start");

endmodule

FILE: src/static_colormap_entry_gen_unit.sv
// Top level of the static colormap entry generator.
//
// The block takes a colormap index and returns the 16-bit red, green and blue
// intensities of that entry for the configured visual class, together with a
// flag saying whether the entry is written and a flag raised when a channel
// divisor or the bits per channel was zero (that channel then reads 0). Items
// are pushed through a queue-like port and results are popped the same way.
// The front part holds the configuration and classifies each item; a two-item
// queue decouples it from the back part, where three channel lanes work in
// parallel and a result register holds the finished item until it is popped,
// while the next item is already being computed. Each lane first strips, in
// the colour classes only, the trailing zero bits of its mask one bit a cycle,
// then runs two radix-2 restoring divisions of 26 and 42 steps, each ending
// with a hand-over. An entry that is not written skips normalisation and both
// divisions, and a zero divisor ends a lane after normalisation. The lanes set
// the sustained rate. Configuration should be written only while the block is
// idle.
module static_colormap_entry_gen_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [scegen_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [scegen_pkg::MaskBits-1:0]     csr_write_data,
   input  logic                                push,
   output logic                                full,
   input  logic [scegen_pkg::IndexBits-1:0]    req_entry_index,
   output logic                                empty,
   input  logic                                pop,
   output logic [scegen_pkg::OutBits-1:0]      rsp_red_value,
   output logic [scegen_pkg::OutBits-1:0]      rsp_green_value,
   output logic [scegen_pkg::OutBits-1:0]      rsp_blue_value,
   output logic                                rsp_entry_written,
   output logic                                rsp_divide_fault
);

   scegen_pkg::task_type front_task;
   scegen_pkg::task_type queue_head;
   logic                 queue_empty;
   logic                 queue_pop;
   logic                 accept;

   // An item is taken whenever the queue has room.
   assign accept = push && !full;

   scegen_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_entry_index  (req_entry_index),
      .task_out         (front_task)
   );

   scegen_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_task),
      .pop       (queue_pop),
      .full      (full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   scegen_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_head        (queue_head),
      .queue_pop         (queue_pop),
      .rsp_pop           (pop),
      .rsp_empty         (empty),
      .rsp_red_value     (rsp_red_value),
      .rsp_green_value   (rsp_green_value),
      .rsp_blue_value    (rsp_blue_value),
      .rsp_entry_written (rsp_entry_written),
      .rsp_divide_fault  (rsp_divide_fault)
   );

endmodule
